/* rtl/core/jpcp_pkg.sv */
// jpcp_pkg: shared constants, codes and types of the jtag probe command parser
// used by jpcp_ctrl, jpcp_datapath and jtag_probe_command_parser
package jpcp_pkg;

    localparam int MAX_SHIFT_BYTES = 62;
    localparam int ADDR_W = (MAX_SHIFT_BYTES > 1) ? $clog2(MAX_SHIFT_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_SHIFT_BYTES + 1);
    localparam logic [9:0] SHIFT_BITS_MAX = 10'(MAX_SHIFT_BYTES * 8);
    localparam logic [9:0] SHIFT_BITS_LONG = 10'd256;

    localparam logic [15:0] TX_CAP_RESET    = 16'd64;
    localparam logic [15:0] INFO_RESP_BYTES = 16'd10;

    localparam int CMD_BIT_NOREAD = 7;
    localparam int CMD_BIT_LONG   = 6;

    localparam logic [3:0] CMD_STOP    = 4'h0;
    localparam logic [3:0] CMD_INFO    = 4'h1;
    localparam logic [3:0] CMD_FREQ    = 4'h2;
    localparam logic [3:0] CMD_SHIFT   = 4'h3;
    localparam logic [3:0] CMD_PINS    = 4'h4;
    localparam logic [3:0] CMD_SAMPLE  = 4'h5;
    localparam logic [3:0] CMD_CLOCK   = 4'h6;
    localparam logic [3:0] CMD_RELEASE = 4'h7;

    localparam logic [2:0] KIND_INFO   = 3'd0;
    localparam logic [2:0] KIND_FREQ   = 3'd1;
    localparam logic [2:0] KIND_SHIFT  = 3'd2;
    localparam logic [2:0] KIND_PINS   = 3'd3;
    localparam logic [2:0] KIND_SAMPLE = 3'd4;
    localparam logic [2:0] KIND_CLOCK  = 3'd5;
    localparam logic [2:0] KIND_DONE   = 3'd6;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_TRUNC       = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW    = 2'd2;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd3;

    localparam int PIN_BIT_TDI = 2;
    localparam int PIN_BIT_TMS = 4;
    localparam logic [7:0] PIN_TCK  = 8'h02;
    localparam logic [7:0] PIN_TDI  = 8'h04;
    localparam logic [7:0] PIN_TMS  = 8'h10;
    localparam logic [7:0] PIN_TRST = 8'h20;
    localparam logic [7:0] PIN_SRST = 8'h40;
    localparam logic [7:0] PIN_ALL  = PIN_TCK | PIN_TDI | PIN_TMS | PIN_TRST | PIN_SRST;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  signal_mask;
        logic [8:0]  bit_count;
        logic [15:0] freq_khz;
        logic        tms_level;
        logic        tdi_level;
        logic        read_back;
        logic [1:0]  status;
        logic [15:0] response_length;
        logic        release_res;
        logic        last_of_run;
    } t_item;

    typedef enum logic [1:0] {
        SRC_ACCEPT = 2'd0,
        SRC_SHIFT  = 2'd1,
        SRC_DONE   = 2'd2
    } t_src;

    typedef struct packed {
        logic              accept;
        logic              load;
        t_src              src;
        logic              last;
        logic [ADDR_W-1:0] rd_addr;
    } t_ctrl_cmd;

    typedef struct packed {
        logic             single;
        logic             run;
        logic [CNT_W-1:0] nbytes;
        logic             eop;
    } t_dp_status;

endpackage

/* rtl/core/jpcp_ram.sv */
// jpcp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module jpcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/jpcp_ctrl.sv */
// jpcp_ctrl: sequencer of the parser, input handshake, shift run and done item
// depends on jpcp_pkg
module jpcp_ctrl import jpcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_RUN   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_run_eop, n_run_eop;
    logic              out_free;
    logic              in_ready;
    logic              is_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign is_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_run_eop   = r_run_eop;
        o_cmd       = '0;
        o_cmd.src   = SRC_ACCEPT;
        o_cmd.accept  = i_in_valid && in_ready;
        o_cmd.rd_addr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_status.single) begin
                        o_cmd.load = 1'b1;
                        o_cmd.last = !i_status.eop;
                        if (i_status.eop) begin
                            n_state = S_DONE;
                        end
                    end else if (i_status.run) begin
                        n_state   = S_PRIME;
                        n_count   = i_status.nbytes;
                        n_run_eop = i_status.eop;
                        n_idx     = '0;
                    end else if (i_status.eop) begin
                        o_cmd.load = 1'b1;
                        o_cmd.last = 1'b1;
                    end
                end
            end
            S_PRIME: begin
                // first read of the run is in flight
                n_state = S_RUN;
            end
            S_RUN: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_SHIFT;
                    o_cmd.last = is_last && !r_run_eop;
                    if (is_last) begin
                        n_state = r_run_eop ? S_DONE : S_IDLE;
                    end else begin
                        n_idx         = ADDR_W'(r_idx + 1'b1);
                        o_cmd.rd_addr = n_idx;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = SRC_DONE;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_run_eop   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_run_eop   <= n_run_eop;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/jpcp_datapath.sv */
// jpcp_datapath: packet state, command decode, shift data store and result register
// depends on jpcp_pkg and jpcp_ram
module jpcp_datapath import jpcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_packet,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_status,
    output t_item       o_item
);

    logic [15:0] r_cap;
    logic [7:0]  r_cmd, n_cmd;
    logic [6:0]  r_pos, n_pos, p_pos;
    logic [7:0]  r_arg1, n_arg1;
    logic [15:0] r_used, n_used, p_used;
    logic        r_halted, n_halted, p_halted;
    logic [1:0]  r_status, n_status, p_status;
    logic        r_release, n_release, p_release;

    logic [8:0]  r_run_bits;
    logic        r_run_rb;
    logic [15:0] r_run_len;
    logic [1:0]  r_run_status;
    logic        r_run_rel;
    logic [1:0]  r_done_status;
    logic [15:0] r_done_len;
    logic        r_done_rel;

    t_item       single_item, done_item, r_item, n_item;
    logic        single, run;
    logic [9:0]  bits;
    logic [6:0]  nbytes;
    logic [6:0]  idx;
    logic        rb, readout, ok;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [1:0]  done_status;

    function automatic logic can_reserve(input logic [15:0] used, input logic [15:0] cap,
                                         input logic [15:0] need);
        can_reserve = (used <= cap) && (need <= (cap - used));
    endfunction

    function automatic logic [9:0] shift_bits(input logic [7:0] arg, input logic [7:0] cmd);
        logic [9:0] sum;
        sum = {2'b00, arg} + (cmd[CMD_BIT_LONG] ? SHIFT_BITS_LONG : 10'd0);
        if (sum > SHIFT_BITS_MAX) begin
            sum = SHIFT_BITS_MAX;
        end
        shift_bits = sum;
    endfunction

    always_comb begin
        n_cmd       = r_cmd;
        n_arg1      = r_arg1;
        p_pos       = r_pos;
        p_used      = r_used;
        p_halted    = r_halted;
        p_status    = r_status;
        p_release   = r_release;
        single      = 1'b0;
        run         = 1'b0;
        ram_we      = 1'b0;
        single_item = '0;
        bits        = shift_bits(r_arg1, r_cmd);
        nbytes      = 7'((11'(bits) + 11'd7) >> 3);
        idx         = r_pos - 7'd2;
        rb          = !r_cmd[CMD_BIT_NOREAD];
        readout     = r_cmd[CMD_BIT_NOREAD];
        ok          = !readout || can_reserve(r_used, r_cap, 16'd1);
        if (!r_halted) begin
            if (r_pos == 7'd0) begin
                n_cmd = i_rx_byte;
                case (i_rx_byte[3:0])
                    CMD_STOP: begin
                        p_halted = 1'b1;
                    end
                    CMD_INFO: begin
                        if (can_reserve(r_used, r_cap, INFO_RESP_BYTES)) begin
                            p_used           = r_used + INFO_RESP_BYTES;
                            single           = 1'b1;
                            single_item.kind = KIND_INFO;
                        end else begin
                            p_status = STAT_OVERFLOW;
                            p_halted = 1'b1;
                        end
                    end
                    CMD_FREQ, CMD_SHIFT, CMD_PINS, CMD_CLOCK: begin
                        p_pos = 7'd1;
                    end
                    CMD_SAMPLE: begin
                        if (can_reserve(r_used, r_cap, 16'd1)) begin
                            p_used                = r_used + 16'd1;
                            single                = 1'b1;
                            single_item.kind      = KIND_SAMPLE;
                            single_item.read_back = 1'b1;
                        end else begin
                            p_status = STAT_OVERFLOW;
                            p_halted = 1'b1;
                        end
                    end
                    CMD_RELEASE: begin
                        p_release = 1'b1;
                        p_halted  = 1'b1;
                    end
                    default: begin
                        p_status = STAT_UNSUPPORTED;
                        p_halted = 1'b1;
                    end
                endcase
            end else if (r_pos == 7'd1) begin
                n_arg1 = i_rx_byte;
                p_pos  = 7'd2;
                if ((r_cmd[3:0] == CMD_SHIFT) && (shift_bits(i_rx_byte, r_cmd) == 10'd0)) begin
                    p_pos = 7'd0;
                end
            end else if (r_cmd[3:0] == CMD_SHIFT) begin
                ram_we = 1'b1;
                p_pos  = r_pos + 7'd1;
                if ((idx + 7'd1) >= nbytes) begin
                    p_pos = 7'd0;
                    if (rb && !can_reserve(r_used, r_cap, 16'(nbytes))) begin
                        p_status = STAT_OVERFLOW;
                        p_halted = 1'b1;
                    end else begin
                        if (rb) begin
                            p_used = r_used + 16'(nbytes);
                        end
                        run = 1'b1;
                    end
                end
            end else begin
                p_pos = 7'd0;
                case (r_cmd[3:0])
                    CMD_FREQ: begin
                        single               = 1'b1;
                        single_item.kind     = KIND_FREQ;
                        single_item.freq_khz = {r_arg1, i_rx_byte};
                    end
                    CMD_PINS: begin
                        single                  = 1'b1;
                        single_item.kind        = KIND_PINS;
                        single_item.data_byte   = i_rx_byte;
                        single_item.signal_mask = r_arg1 & PIN_ALL;
                    end
                    CMD_CLOCK: begin
                        single                = 1'b1;
                        single_item.kind      = KIND_CLOCK;
                        single_item.bit_count = {1'b0, i_rx_byte};
                        single_item.tms_level = r_arg1[PIN_BIT_TMS];
                        single_item.tdi_level = r_arg1[PIN_BIT_TDI];
                        single_item.read_back = readout && ok;
                        if (readout && ok) begin
                            p_used = r_used + 16'd1;
                        end
                        if (!ok) begin
                            p_status = STAT_OVERFLOW;
                            p_halted = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        // clock item carries the status from before its own overflow
        single_item.status          = r_status;
        single_item.response_length = p_used;
        single_item.release_res     = r_release;

        done_status = p_status;
        if (!p_halted && (p_pos != 7'd0)) begin
            done_status = STAT_TRUNC;
        end
        done_item                 = '0;
        done_item.kind            = KIND_DONE;
        done_item.status          = done_status;
        done_item.response_length = p_used;
        done_item.release_res     = p_release;

        if (i_end_of_packet) begin
            n_cmd     = '0;
            n_arg1    = '0;
            n_pos     = '0;
            n_used    = '0;
            n_halted  = 1'b0;
            n_status  = STAT_OK;
            n_release = 1'b0;
        end else begin
            n_pos     = p_pos;
            n_used    = p_used;
            n_halted  = p_halted;
            n_status  = p_status;
            n_release = p_release;
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_ACCEPT: begin
                n_item = single ? single_item : done_item;
            end
            SRC_SHIFT: begin
                n_item                 = '0;
                n_item.kind            = KIND_SHIFT;
                n_item.data_byte       = ram_rdata;
                n_item.bit_count       = r_run_bits;
                n_item.read_back       = r_run_rb;
                n_item.status          = r_run_status;
                n_item.response_length = r_run_len;
                n_item.release_res     = r_run_rel;
            end
            SRC_DONE: begin
                n_item                 = '0;
                n_item.kind            = KIND_DONE;
                n_item.status          = r_done_status;
                n_item.response_length = r_done_len;
                n_item.release_res     = r_done_rel;
            end
            default: begin
                n_item = '0;
            end
        endcase
        n_item.last_of_run = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= TX_CAP_RESET;
            r_cmd     <= '0;
            r_pos     <= '0;
            r_arg1    <= '0;
            r_used    <= '0;
            r_halted  <= 1'b0;
            r_status  <= STAT_OK;
            r_release <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_cmd     <= n_cmd;
                r_pos     <= n_pos;
                r_arg1    <= n_arg1;
                r_used    <= n_used;
                r_halted  <= n_halted;
                r_status  <= n_status;
                r_release <= n_release;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && run) begin
            r_run_bits   <= bits[8:0];
            r_run_rb     <= rb;
            r_run_len    <= p_used;
            r_run_status <= p_status;
            r_run_rel    <= p_release;
        end
        if (i_cmd.accept && i_end_of_packet) begin
            r_done_status <= done_status;
            r_done_len    <= p_used;
            r_done_rel    <= p_release;
        end
        if (i_cmd.load) begin
            r_item <= n_item;
        end
    end

    jpcp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SHIFT_BYTES)
    ) u_shift_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && ram_we),
        .i_waddr (idx[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_status.single = single;
    assign o_status.run    = run;
    assign o_status.nbytes = CNT_W'(nbytes);
    assign o_status.eop    = i_end_of_packet;
    assign o_item          = r_item;

endmodule

/* rtl/core/jtag_probe_command_parser.sv */
// jtag_probe_command_parser: top level, decodes probe command packets into pin engine items
// depends on jpcp_pkg, jpcp_ctrl, jpcp_datapath (and jpcp_ram below it)
//
// input channel: one packet byte per transfer on i_in_valid / o_in_ready, with
// i_end_of_packet set on the last byte of the packet.
// output channel: one action item per transfer on o_out_valid / i_out_ready;
// o_last_of_run marks the final item caused by one input byte.
// config: i_cfg_we writes i_cfg_data into the response capacity (reset 64); the
// user must write it only while no byte is in progress, the block does not enforce it.
// sequencing: an item caused directly by a byte sits in the output register in the
// cycle after the byte transfer. a shift run of data bytes is read from the shift
// data RAM one byte per cycle while the receiver does not stall, through a prime
// state after the last data byte; a packet done item after an action item comes
// from a separate done state.
// bytes are not taken while a run or a done item is pending, nor while the
// output register is full and the receiver stalls.
// reset: synchronous, active low; clears all packet state and the sequencer,
// the shift data RAM needs no clearing.
module jtag_probe_command_parser import jpcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_signal_mask,
    output logic [8:0]  o_bit_count,
    output logic [15:0] o_freq_khz,
    output logic        o_tms_level,
    output logic        o_tdi_level,
    output logic        o_read_back,
    output logic [1:0]  o_status,
    output logic [15:0] o_response_length,
    output logic        o_release_res,
    output logic        o_last_of_run
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;
    t_item      item;

    jpcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    jpcp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .o_item          (item)
    );

    assign o_kind            = item.kind;
    assign o_data_byte       = item.data_byte;
    assign o_signal_mask     = item.signal_mask;
    assign o_bit_count       = item.bit_count;
    assign o_freq_khz        = item.freq_khz;
    assign o_tms_level       = item.tms_level;
    assign o_tdi_level       = item.tdi_level;
    assign o_read_back       = item.read_back;
    assign o_status          = item.status;
    assign o_response_length = item.response_length;
    assign o_release_res     = item.release_res;
    assign o_last_of_run     = item.last_of_run;

`ifndef NO_ASSERTIONS
    a_no_accept_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (!o_out_valid || i_out_ready))
        else $error("byte taken while a stalled result is pending");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_DONE)) |-> o_last_of_run)
        else $error("packet done item not marked last");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind <= KIND_DONE))
        else $error("result kind out of range");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");
`endif

endmodule

/* test/jtag_probe_command_parser_tb.sv */
`timescale 1ns / 1ps
// jtag_probe_command_parser_tb: self-checking bench for the probe command parser
// sends command packets, predicts every action item and checks each output transfer
// depends on jpcp_pkg and jtag_probe_command_parser
module jtag_probe_command_parser_tb;
    import jpcp_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_BYTES = 48;
    localparam int CALM_BYTES   = 12;
    localparam int HOLD_CYCLES  = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        i_end_of_packet;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_signal_mask;
    logic [8:0]  o_bit_count;
    logic [15:0] o_freq_khz;
    logic        o_tms_level;
    logic        o_tdi_level;
    logic        o_read_back;
    logic [1:0]  o_status;
    logic [15:0] o_response_length;
    logic        o_release_res;
    logic        o_last_of_run;

    // parser state as predicted
    logic [15:0] cap_model;
    logic [7:0]  cur_cmd;
    int unsigned cmd_pos;
    int unsigned reserved;
    logic [7:0]  arg_first;
    logic [7:0]  shift_buf [MAX_SHIFT_BYTES];
    logic        halted;
    logic [1:0]  pkt_status;
    logic        release_flag;
    t_item       pending_actions[$];

    logic [7:0]  pkt_q[$];
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;

    jtag_probe_command_parser DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_packet   (i_end_of_packet),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_signal_mask     (o_signal_mask),
        .o_bit_count       (o_bit_count),
        .o_freq_khz        (o_freq_khz),
        .o_tms_level       (o_tms_level),
        .o_tdi_level       (o_tdi_level),
        .o_read_back       (o_read_back),
        .o_status          (o_status),
        .o_response_length (o_response_length),
        .o_release_res     (o_release_res),
        .o_last_of_run     (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_packet_model();
        cur_cmd      = '0;
        cmd_pos      = 0;
        arg_first    = '0;
        reserved     = 0;
        halted       = 1'b0;
        pkt_status   = STAT_OK;
        release_flag = 1'b0;
    endfunction

    function automatic logic room_for(input int unsigned need);
        return reserved <= cap_model && need <= cap_model - reserved;
    endfunction

    function automatic void halt_with(input logic [1:0] code);
        pkt_status = code;
        halted     = 1'b1;
        cmd_pos    = 0;
    endfunction

    function automatic int unsigned shift_bit_total();
        int unsigned bits;
        bits = arg_first;
        if (cur_cmd[CMD_BIT_LONG]) bits += SHIFT_BITS_LONG;
        if (bits > SHIFT_BITS_MAX) bits = SHIFT_BITS_MAX;
        return bits;
    endfunction

    function automatic void queue_action(input logic [2:0] kind, input logic [7:0] data,
                                         input logic [7:0] mask, input logic [8:0] bits,
                                         input logic [15:0] freq, input logic tms,
                                         input logic tdi, input logic rb);
        t_item a;
        a.kind            = kind;
        a.data_byte       = data;
        a.signal_mask     = mask;
        a.bit_count       = bits;
        a.freq_khz        = freq;
        a.tms_level       = tms;
        a.tdi_level       = tdi;
        a.read_back       = rb;
        a.status          = pkt_status;
        a.response_length = reserved[15:0];
        a.release_res     = release_flag;
        a.last_of_run     = 1'b0;
        pending_actions.push_back(a);
    endfunction

    function automatic void predict_actions(input logic [7:0] b, input logic eop);
        int          base;
        int unsigned bits;
        int unsigned nbytes;
        int unsigned idx;
        logic        rb;
        logic        readout;
        logic        room;
        t_item       tail;
        base = pending_actions.size();
        if (!halted) begin
            if (cmd_pos == 0) begin
                cur_cmd = b;
                case (b[3:0])
                    CMD_STOP: begin
                        halted = 1'b1;
                    end
                    CMD_INFO: begin
                        if (room_for(INFO_RESP_BYTES)) begin
                            reserved += INFO_RESP_BYTES;
                            queue_action(KIND_INFO, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
                        end else begin
                            halt_with(STAT_OVERFLOW);
                        end
                    end
                    CMD_FREQ, CMD_SHIFT, CMD_PINS, CMD_CLOCK: begin
                        cmd_pos = 1;
                    end
                    CMD_SAMPLE: begin
                        if (room_for(1)) begin
                            reserved += 1;
                            queue_action(KIND_SAMPLE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            halt_with(STAT_OVERFLOW);
                        end
                    end
                    CMD_RELEASE: begin
                        release_flag = 1'b1;
                        halted = 1'b1;
                    end
                    default: begin
                        halt_with(STAT_UNSUPPORTED);
                    end
                endcase
            end else if (cmd_pos == 1) begin
                arg_first = b;
                cmd_pos = 2;
                if (cur_cmd[3:0] == CMD_SHIFT && shift_bit_total() == 0) cmd_pos = 0;
            end else if (cur_cmd[3:0] == CMD_SHIFT) begin
                bits = shift_bit_total();
                nbytes = (bits + 7) / 8;
                idx = cmd_pos - 2;
                rb = !cur_cmd[CMD_BIT_NOREAD];
                if (idx < MAX_SHIFT_BYTES) shift_buf[idx] = b;
                cmd_pos = cmd_pos + 1;
                if (idx + 1 >= nbytes) begin
                    cmd_pos = 0;
                    if (rb && !room_for(nbytes)) begin
                        halt_with(STAT_OVERFLOW);
                    end else begin
                        if (rb) reserved += nbytes;
                        for (int i = 0; i < nbytes; i++)
                            queue_action(KIND_SHIFT, shift_buf[i], '0, 9'(bits), '0,
                                         1'b0, 1'b0, rb);
                    end
                end
            end else begin
                cmd_pos = 0;
                case (cur_cmd[3:0])
                    CMD_FREQ: begin
                        queue_action(KIND_FREQ, '0, '0, '0, {arg_first, b}, 1'b0, 1'b0, 1'b0);
                    end
                    CMD_PINS: begin
                        queue_action(KIND_PINS, b, arg_first & PIN_ALL, '0, '0,
                                     1'b0, 1'b0, 1'b0);
                    end
                    default: begin
                        readout = cur_cmd[CMD_BIT_NOREAD];
                        room = !readout || room_for(1);
                        if (readout && room) reserved += 1;
                        queue_action(KIND_CLOCK, '0, '0, {1'b0, b}, '0, arg_first[PIN_BIT_TMS],
                                     arg_first[PIN_BIT_TDI], readout && room);
                        if (!room) halt_with(STAT_OVERFLOW);
                    end
                endcase
            end
        end
        if (eop) begin
            if (!halted && cmd_pos != 0) halt_with(STAT_TRUNC);
            queue_action(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
            clear_packet_model();
        end
        if (pending_actions.size() > base) begin
            tail = pending_actions.pop_back();
            tail.last_of_run = 1'b1;
            pending_actions.push_back(tail);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // output transfers are checked before the same edge's input transfer is predicted
    always @(posedge i_clk) begin : monitor
        t_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_actions.size() == 0) begin
                    $error("unexpected transfer: kind %0d", o_kind);
                    fail_count++;
                end else begin
                    want = pending_actions.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(o_kind));
                    compare_field("data_byte", 16'(want.data_byte), 16'(o_data_byte));
                    compare_field("signal_mask", 16'(want.signal_mask), 16'(o_signal_mask));
                    compare_field("bit_count", 16'(want.bit_count), 16'(o_bit_count));
                    compare_field("freq_khz", want.freq_khz, o_freq_khz);
                    compare_field("tms_level", 16'(want.tms_level), 16'(o_tms_level));
                    compare_field("tdi_level", 16'(want.tdi_level), 16'(o_tdi_level));
                    compare_field("read_back", 16'(want.read_back), 16'(o_read_back));
                    compare_field("status", 16'(want.status), 16'(o_status));
                    compare_field("response_length", want.response_length,
                                  o_response_length);
                    compare_field("release_res", 16'(want.release_res), 16'(o_release_res));
                    compare_field("last_of_run", 16'(want.last_of_run), 16'(o_last_of_run));
                end
            end
            if (i_in_valid && o_in_ready) predict_actions(i_rx_byte, i_end_of_packet);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise random stall bursts while idle_en is set
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        int gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_byte       <= b;
        i_end_of_packet <= eop;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    task automatic send_packet_part();
        for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], 1'b0);
        pkt_q.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        pkt_q.push_back(b);
    endfunction

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_model = value;
    endtask

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 16));
            1:       return TX_CAP_RESET;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(100, 4000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_random_command();
        logic [7:0]  head;
        logic [7:0]  arg;
        int unsigned bits;
        head = 8'($urandom);
        case ($urandom_range(0, 15))
            0: begin
                head[3:0] = CMD_INFO;
                add_byte(head);
            end
            1: begin
                head[3:0] = CMD_FREQ;
                add_byte(head);
                add_byte(8'($urandom));
                add_byte(8'($urandom));
            end
            2, 3, 4, 5: begin
                head[3:0] = CMD_SHIFT;
                head[CMD_BIT_LONG] = ($urandom_range(0, 11) == 0);
                arg = head[CMD_BIT_LONG] ? 8'($urandom) : 8'($urandom_range(0, 40));
                bits = arg + (head[CMD_BIT_LONG] ? SHIFT_BITS_LONG : 0);
                if (bits > SHIFT_BITS_MAX) bits = SHIFT_BITS_MAX;
                add_byte(head);
                add_byte(arg);
                repeat ((bits + 7) / 8) add_byte(8'($urandom));
            end
            6, 7, 15: begin
                head[3:0] = CMD_PINS;
                add_byte(head);
                add_byte(8'($urandom));
                add_byte(8'($urandom));
            end
            8: begin
                head[3:0] = CMD_SAMPLE;
                add_byte(head);
            end
            9, 10: begin
                head[3:0] = CMD_CLOCK;
                add_byte(head);
                add_byte(8'($urandom));
                add_byte(8'($urandom));
            end
            11: begin
                head[3:0] = CMD_STOP;
                add_byte(head);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            end
            12: begin
                head[3:0] = CMD_RELEASE;
                add_byte(head);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            end
            13: begin
                head[3] = 1'b1;
                add_byte(head);
            end
            default: begin
                add_byte(head);
            end
        endcase
    endfunction

    task automatic send_random_packet();
        repeat ($urandom_range(1, 5)) add_random_command();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2))
                if (pkt_q.size() > 1) void'(pkt_q.pop_back());
        end
        send_packet();
    endtask

    task automatic test_basic_commands();
        add_byte({4'h0, CMD_INFO});
        add_byte({4'h0, CMD_FREQ});
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte({4'hF, CMD_PINS});
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte({4'h8, CMD_CLOCK});
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte({4'hF, CMD_SAMPLE});
        send_packet();
    endtask

    task automatic test_shift_lengths();
        // empty shift, then a no-read shift of two bytes
        add_byte({4'h0, CMD_SHIFT});
        add_byte(8'h00);
        add_byte({4'h8, CMD_SHIFT});
        add_byte(8'h09);
        add_byte(8'hAA);
        add_byte(8'h55);
        send_packet();
    endtask

    task automatic test_halting_commands();
        add_byte({4'h0, CMD_STOP});
        add_byte({4'h0, CMD_INFO});
        send_packet();
        add_byte({4'h0, CMD_RELEASE});
        send_packet();
        add_byte(8'h0F);
        add_byte({4'h0, CMD_SAMPLE});
        send_packet();
    endtask

    task automatic test_truncation();
        add_byte({4'h0, CMD_FREQ});
        add_byte(8'h12);
        send_packet();
    endtask

    task automatic test_capacity_limits();
        // clock item goes out before the readout overflow halts the packet
        write_capacity(16'h0000);
        add_byte({4'h8, CMD_CLOCK});
        add_byte(PIN_TMS | PIN_TDI);
        add_byte(8'h03);
        add_byte({4'h0, CMD_INFO});
        send_packet();
        write_capacity(16'd2);
        add_byte({4'h0, CMD_SHIFT});
        add_byte(8'h18);
        repeat (3) add_byte(8'($urandom));
        send_packet();
        // capacity lowered below what the packet already reserved
        write_capacity(16'd11);
        add_byte({4'h0, CMD_INFO});
        send_packet_part();
        write_capacity(16'd5);
        add_byte({4'h0, CMD_SAMPLE});
        send_packet();
        write_capacity(16'hFFFF);
    endtask

    task automatic test_output_stall();
        write_capacity(TX_CAP_RESET);
        idle_en = 1'b0;
        hold_req = 1'b1;
        add_byte({2'b11, 2'b00, CMD_SHIFT});
        add_byte(8'hFF);
        repeat (MAX_SHIFT_BYTES) add_byte(8'($urandom));
        add_byte({4'h0, CMD_PINS});
        add_byte(PIN_ALL);
        add_byte(8'hA5);
        add_byte({4'h8, CMD_CLOCK});
        add_byte(PIN_TMS);
        add_byte(8'd7);
        add_byte({4'h0, CMD_SAMPLE});
        send_packet();
        settle();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES - CALM_BYTES;
        while (bytes_sent < stop_at) begin
            write_capacity(pick_capacity());
            idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) send_random_packet();
        end
    endtask

    task automatic test_calm_traffic();
        int stop_at;
        write_capacity(16'($urandom_range(64, 4000)));
        idle_en = 1'b0;
        stop_at = bytes_sent + CALM_BYTES;
        while (bytes_sent < stop_at) send_random_packet();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_rx_byte       = '0;
        i_end_of_packet = 1'b0;
        cap_model       = TX_CAP_RESET;
        clear_packet_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();
        test_shift_lengths();
        test_halting_commands();
        test_truncation();
        test_capacity_limits();
        test_output_stall();
        test_random_traffic();
        test_calm_traffic();

        settle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
